// ===== rtl/dch_pkg.sv =====
// Shared types, constants and the linear-light table for the dominant color histogram.
// No dependencies; every other file imports this package.
package dch_pkg;

  localparam int unsigned BIN_W        = 9;
  localparam int unsigned NUM_BINS     = 512;
  localparam int unsigned COUNT_W      = 13;
  localparam int unsigned COUNT_MAX    = 8191;
  localparam int unsigned LEVEL_W      = 3;
  localparam int unsigned CNT_W        = 10;  // holds 0..NUM_BINS
  localparam int unsigned LUMA_W       = 16;

  // Q0.16 luminance weights, sum is exactly 1.0
  localparam logic [15:0] WEIGHT_RED   = 16'd13933;
  localparam logic [15:0] WEIGHT_GREEN = 16'd46871;
  localparam logic [15:0] WEIGHT_BLUE  = 16'd4732;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       frame_last;
  } pixel_t;

  typedef struct packed {
    logic [7:0]         dominant_red;
    logic [7:0]         dominant_green;
    logic [7:0]         dominant_blue;
    logic [LUMA_W-1:0]  luminance;
    logic [COUNT_W-1:0] winning_count;
  } result_t;

  // bin RAM write port
  typedef struct packed {
    logic               en;
    logic [BIN_W-1:0]   addr;
    logic [COUNT_W-1:0] data;
  } ram_wr_t;

  // launch of the luminance unit
  typedef struct packed {
    logic               start;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
  } luma_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_LAUNCH,
    ST_LUMA
  } dch_state_e;

  // linearized sRGB of bin centers 16, 48, ..., 240 in Q0.16
  function automatic logic [15:0] lin_of(logic [LEVEL_W-1:0] level);
    logic [15:0] v;
    case (level)
      3'd0:    v = 16'd340;
      3'd1:    v = 16'd1937;
      3'd2:    v = 16'd5257;
      3'd3:    v = 16'd10619;
      3'd4:    v = 16'd18277;
      3'd5:    v = 16'd28453;
      3'd6:    v = 16'd41337;
      3'd7:    v = 16'd57106;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] center_of(logic [LEVEL_W-1:0] level);
    return {level, 5'b10000};
  endfunction

endpackage

// ===== rtl/dch_bin_ram.sv =====
// Bin count memory: 512 x 13, one write port, one read port with registered data.
// Depends on dch_pkg.
module dch_bin_ram (
  input  logic                          clk_i,
  input  dch_pkg::ram_wr_t              wr_i,
  input  logic [dch_pkg::BIN_W-1:0]     rd_addr_i,
  output logic [dch_pkg::COUNT_W-1:0]   rd_data_o
);
  import dch_pkg::*;

  logic [COUNT_W-1:0] mem [NUM_BINS];
  logic [COUNT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // read returns the old value on a same-address write
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/dch_luma.sv =====
// Luminance unit: one 16x16 multiplier and one accumulator stepped over R, G, B,
// then round and saturate. Depends on dch_pkg.
module dch_luma #(
  parameter int unsigned LUMA_FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dch_pkg::luma_req_t          req_i,
  output logic                        done_o,
  output logic [dch_pkg::LUMA_W-1:0]  luminance_o
);
  import dch_pkg::*;

  localparam int unsigned RoundSh   = 32 - LUMA_FRACTION_BITS;
  localparam logic [32:0] RoundHalf = 33'(1) << (RoundSh - 1);
  localparam logic [32:0] LumaCap   = (LUMA_FRACTION_BITS < 16) ?
                                      ((33'(1) << LUMA_FRACTION_BITS) - 33'd1) : 33'd65535;
  localparam logic [2:0]  StepRound = 3'd4;
  localparam logic [2:0]  StepLast  = 3'd3;

  logic               running_q, running_d;
  logic [2:0]         step_q, step_d;
  logic               done_q, done_d;
  logic [LEVEL_W-1:0] red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [31:0]        prod_q, prod_d;
  logic [32:0]        acc_q, acc_d;
  logic [LUMA_W-1:0]  lum_q, lum_d;

  logic [15:0]        mul_w;
  logic [LEVEL_W-1:0] mul_lvl;
  logic [31:0]        mul_p;
  logic [32:0]        rounded;

  always_comb begin
    case (step_q)
      3'd0:    begin mul_w = WEIGHT_RED;   mul_lvl = red_q;   end
      3'd1:    begin mul_w = WEIGHT_GREEN; mul_lvl = green_q; end
      default: begin mul_w = WEIGHT_BLUE;  mul_lvl = blue_q;  end
    endcase
  end

  assign mul_p   = mul_w * lin_of(mul_lvl);
  assign rounded = (acc_q + RoundHalf) >> RoundSh;

  always_comb begin
    running_d = running_q;
    step_d    = step_q;
    done_d    = 1'b0;
    red_d     = red_q;
    green_d   = green_q;
    blue_d    = blue_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    lum_d     = lum_q;
    if (req_i.start) begin
      running_d = 1'b1;
      step_d    = 3'd0;
      acc_d     = '0;
      red_d     = req_i.red_level;
      green_d   = req_i.green_level;
      blue_d    = req_i.blue_level;
    end else if (running_q) begin
      step_d = step_q + 3'd1;
      // multiply on steps 0..2, accumulate the registered product on steps 1..3
      if (step_q < StepLast) begin
        prod_d = mul_p;
      end
      if (step_q != 3'd0 && step_q <= StepLast) begin
        acc_d = acc_q + 33'(prod_q);
      end
      if (step_q == StepRound) begin
        lum_d     = (rounded > LumaCap) ? LumaCap[LUMA_W-1:0] : rounded[LUMA_W-1:0];
        done_d    = 1'b1;
        running_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      step_q    <= 3'd0;
      done_q    <= 1'b0;
    end else begin
      running_q <= running_d;
      step_q    <= step_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    lum_q   <= lum_d;
  end

  assign done_o      = done_q;
  assign luminance_o = lum_q;

endmodule

// ===== rtl/dominant_color_histogram.sv =====
// Top level of the dominant color histogram: sequencer, bin update and scan compare.
// Depends on dch_pkg, dch_bin_ram and dch_luma.
//
//   channel   | handshake               | beat
//   ----------+-------------------------+-----------------------------------------
//   pixel in  | start & !busy           | pixel_i  (RGB888 + frame_last)
//   result    | result_valid_o (1 cyc)  | result_o (center RGB, luminance, count)
//
// For each pixel, the accept cycle issues a registered read of its bin,
// then busy is high for one cycle while the incremented count is written back
// (single bin RAM, read-modify-write).
// A pixel with frame_last adds a scan of all bins (one bin per cycle through the
// compare unit, clearing each bin as it is read), a launch state and a wait on the
// luminance unit (5 steps, then its done cycle); the result strobe
// is high in the first cycle that busy is low again.
// After reset the bin RAM is zeroed with busy high.
// The result port has no back-pressure; each result beat is valid one cycle.
module dominant_color_histogram #(
  parameter int unsigned MAX_FRAME_PIXELS   = 4096,
  parameter int unsigned LUMA_FRACTION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dch_pkg::pixel_t   pixel_i,
  output logic              result_valid_o,
  output dch_pkg::result_t  result_o
);
  import dch_pkg::*;

  // a bin saturates at the frame size or the field maximum, whichever is lower
  localparam int unsigned    CountCap  = (MAX_FRAME_PIXELS < COUNT_MAX) ?
                                         MAX_FRAME_PIXELS : COUNT_MAX;
  localparam logic [COUNT_W-1:0] CountCapW = COUNT_W'(CountCap);
  localparam logic [CNT_W-1:0]   LastBin   = CNT_W'(NUM_BINS - 1);
  localparam logic [CNT_W-1:0]   ScanEnd   = CNT_W'(NUM_BINS);

  dch_state_e state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [BIN_W-1:0]   bin_q, bin_d;
  logic               last_q, last_d;
  logic [BIN_W-1:0]   best_bin_q, best_bin_d;
  logic [COUNT_W-1:0] best_cnt_q, best_cnt_d;
  logic               res_valid_q;
  result_t            res_q;

  ram_wr_t            ram_wr;
  logic [BIN_W-1:0]   ram_rd_addr;
  logic [COUNT_W-1:0] ram_rd_data;
  luma_req_t          luma_req;
  logic               luma_done;
  logic [LUMA_W-1:0]  luma_val;

  logic               accept;
  logic [BIN_W-1:0]   pix_bin;
  logic [BIN_W-1:0]   cmp_bin;

  assign accept  = start && (state_q == ST_IDLE);
  assign pix_bin = {pixel_i.pixel_red[7:5], pixel_i.pixel_green[7:5], pixel_i.pixel_blue[7:5]};
  // bin whose count arrives from the RAM this cycle during the scan
  assign cmp_bin = BIN_W'(cnt_q - CNT_W'(1));

  dch_bin_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  dch_luma #(
    .LUMA_FRACTION_BITS (LUMA_FRACTION_BITS)
  ) u_luma (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (luma_req),
    .done_o      (luma_done),
    .luminance_o (luma_val)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    bin_d       = bin_q;
    last_d      = last_q;
    best_bin_d  = best_bin_q;
    best_cnt_d  = best_cnt_q;
    ram_wr      = '0;
    ram_rd_addr = pix_bin;
    luma_req    = '0;
    case (state_q)
      ST_CLEAR: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = cnt_q[BIN_W-1:0];
        ram_wr.data = '0;
        if (cnt_q == LastBin) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        // read of the pixel's bin is issued in the accept cycle
        if (accept) begin
          bin_d   = pix_bin;
          last_d  = pixel_i.frame_last;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        ram_rd_addr = bin_q;
        ram_wr.en   = 1'b1;
        ram_wr.addr = bin_q;
        ram_wr.data = (ram_rd_data < CountCapW) ? ram_rd_data + COUNT_W'(1) : ram_rd_data;
        if (last_q) begin
          cnt_d      = '0;
          best_bin_d = '0;
          best_cnt_d = '0;
          state_d    = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // read and clear bin cnt, compare the bin read in the previous cycle
        ram_rd_addr = cnt_q[BIN_W-1:0];
        if (cnt_q != ScanEnd) begin
          ram_wr.en   = 1'b1;
          ram_wr.addr = cnt_q[BIN_W-1:0];
          ram_wr.data = '0;
        end
        if (cnt_q != '0 && ram_rd_data > best_cnt_q) begin
          // strict compare keeps the lowest index on ties
          best_cnt_d = ram_rd_data;
          best_bin_d = cmp_bin;
        end
        if (cnt_q == ScanEnd) begin
          cnt_d   = '0;
          state_d = ST_LAUNCH;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_LAUNCH: begin
        luma_req.start       = 1'b1;
        luma_req.red_level   = best_bin_q[8:6];
        luma_req.green_level = best_bin_q[5:3];
        luma_req.blue_level  = best_bin_q[2:0];
        state_d              = ST_LUMA;
      end
      ST_LUMA: begin
        if (luma_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= luma_done && (state_q == ST_LUMA);
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    last_q     <= last_d;
    best_bin_q <= best_bin_d;
    best_cnt_q <= best_cnt_d;
    if (luma_done) begin
      res_q.dominant_red   <= center_of(best_bin_q[8:6]);
      res_q.dominant_green <= center_of(best_bin_q[5:3]);
      res_q.dominant_blue  <= center_of(best_bin_q[2:0]);
      res_q.luminance      <= luma_val;
      res_q.winning_count  <= best_cnt_q;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // a frame result always carries at least the last pixel
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.winning_count != '0)
    else $error("result with zero winning count");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted pixel did not raise busy");

  a_center_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.dominant_red[4:0] == 5'h10 &&
                        result_o.dominant_blue[4:0] == 5'h10))
    else $error("bin center low bits wrong");

  a_luma_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LAUNCH) |-> $past(state_q == ST_SCAN))
    else $error("luminance launched outside a frame end");

endmodule
